FILE: rtl/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_BYTES   = 4096;
   localparam int HEADER_BYTES = 8;
   localparam int ADDR_W       = $clog2(HEAP_BYTES);
   localparam int SIZE_W       = ADDR_W + 1;
   localparam int REQ_W        = 13;
   localparam int NEED_W       = REQ_W + 1;

   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO      = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [1:0] ST_BAD_FREE  = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [REQ_W-1:0]  request_bytes;
      logic [11:0]       payload_offset_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] payload_offset;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              used;
   } hdr_type;

endpackage

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: header store, chain walk and request/response control.
// Allocate reads and checks each header visited on the chain, then writes the update and
// responds; free reads and rewrites one header; reinitialize and rejects skip the walk.
// The header memory has one read and one write port; each header visit is one read.
// One request is in flight at a time; a finished response may wait in the output register.
// Synchronous reset restores a single free range covering the heap at offset 0.
module first_fit_heap_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_WR2  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [1:0]        act_ff, act_in;
   logic [SIZE_W-1:0] rest_ff, rest_in;
   logic [ADDR_W-1:0] far_ff, far_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff;
   logic              rsp_valid_ff;
   hdr_type           hdr0_ff;

   // Entry 0 lives in flip-flops so that reset can restore it; the rest is memory.
   hdr_type           mem [HEAP_BYTES];
   hdr_type           mem_q_ff;
   logic              rd_zero_ff;
   hdr_type           rd_hdr;

   logic              hdr_we;
   logic [ADDR_W-1:0] hdr_waddr;
   hdr_type           hdr_wdata;

   logic              out_free;
   logic [NEED_W-1:0] next_pos;
   logic [NEED_W-1:0] far_pos;
   logic [SIZE_W-1:0] rest;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_hdr    = rd_zero_ff ? hdr0_ff : mem_q_ff;

   assign next_pos = NEED_W'(pos_ff) + NEED_W'(rd_hdr.size);
   assign far_pos  = NEED_W'(pos_ff) + need_ff;
   assign rest     = rd_hdr.size - need_ff[SIZE_W-1:0];

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      need_in   = need_ff;
      act_in    = act_ff;
      rest_in   = rest_ff;
      far_in    = far_ff;
      res_in    = res_ff;
      hdr_we    = 1'b0;
      hdr_waddr = pos_ff;
      hdr_wdata = rd_hdr;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in  = req_data.action;
               need_in = NEED_W'(req_data.request_bytes) + NEED_W'(HEADER_BYTES);
               pos_in  = '0;
               res_in  = '{status: ST_OK, payload_offset: '0};
               state_in = S_RESP;
               case (req_data.action)
                  ACT_INIT: begin
                     hdr_we    = 1'b1;
                     hdr_waddr = '0;
                     hdr_wdata = '{size: SIZE_W'(HEAP_BYTES), used: 1'b0};
                  end
                  ACT_ALLOC: begin
                     if (req_data.request_bytes == '0) begin
                        res_in.status = ST_ZERO;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  ACT_FREE: begin
                     // Offset 0 is a null pointer and is ignored.
                     if (req_data.payload_offset_in == '0) begin
                        res_in.status = ST_OK;
                     end else if (req_data.payload_offset_in < ADDR_W'(HEADER_BYTES)) begin
                        res_in.status = ST_BAD_FREE;
                     end else begin
                        pos_in   = req_data.payload_offset_in - ADDR_W'(HEADER_BYTES);
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = S_RESP;
            if (act_ff == ACT_FREE) begin
               if (rd_hdr.size == '0) begin
                  res_in.status = ST_BAD_FREE;
               end else begin
                  hdr_we    = 1'b1;
                  hdr_wdata = '{size: rd_hdr.size, used: 1'b0};
               end
            end else if (rd_hdr.size == '0) begin
               // A zero-size header means the chain is broken; stop the walk.
               res_in.status = ST_EXHAUSTED;
            end else if (!rd_hdr.used && NEED_W'(rd_hdr.size) >= need_ff) begin
               hdr_we    = 1'b1;
               hdr_wdata = '{size: need_ff[SIZE_W-1:0], used: 1'b1};
               res_in.payload_offset = pos_ff + ADDR_W'(HEADER_BYTES);
               rest_in = rest;
               far_in  = far_pos[ADDR_W-1:0];
               if (rest != '0 && far_pos < NEED_W'(HEAP_BYTES)) begin
                  state_in = S_WR2;
               end
            end else if (next_pos >= NEED_W'(HEAP_BYTES)) begin
               res_in.status = ST_EXHAUSTED;
            end else begin
               pos_in   = next_pos[ADDR_W-1:0];
               state_in = S_RD;
            end
         end
         S_WR2: begin
            hdr_we    = 1'b1;
            hdr_waddr = far_ff;
            hdr_wdata = '{size: rest_ff, used: 1'b0};
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hdr0_ff      <= '{size: SIZE_W'(HEAP_BYTES), used: 1'b0};
      end else begin
         state_ff <= state_in;
         if (state_ff == S_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (hdr_we && hdr_waddr == '0) begin
            hdr0_ff <= hdr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      need_ff <= need_in;
      act_ff  <= act_in;
      rest_ff <= rest_in;
      far_ff  <= far_in;
      res_ff  <= res_in;
      if (state_ff == S_RESP && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Header memory: one write port, one registered read port addressed by the walk.
   always_ff @(posedge clock) begin
      if (hdr_we && hdr_waddr != '0) begin
         mem[hdr_waddr] <= hdr_wdata;
      end
      mem_q_ff   <= mem[pos_ff];
      rd_zero_ff <= (pos_ff == '0);
   end

endmodule
